FILE: hdl/rssim_pkg.sv
`default_nettype none

package rssim_pkg;

  // Fixed field widths of one report and one result
  localparam int ADDR_W  = 48;
  localparam int KIND_W  = 2;
  localparam int SIG_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int SEEN_W  = 16;

  // The quotient of a mean update always fits in SIG_W magnitude bits (|q| <= 128)
  localparam int DIV_STEPS  = SIG_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic signed [SIG_W-1:0] sig_t;

endpackage

`default_nettype wire

FILE: hdl/per_device_rssi_mean_table.sv
`default_nettype none

// Per-device RSSI mean table. Pulse start with a report (address, address type, signed dBm)
// while busy is low; busy stays high until the single result strobe out_valid, which lasts
// one cycle and cannot be held off. The table is scanned one slot per cycle through the
// single read port of the slot RAM; a new device or a dropped report is resolved once the
// whole table has been scanned. A known device found in slot k is resolved in these steps:
// the scan reaches it, the count and mean are multiplied, the divider is loaded, the serial
// restoring divide runs, the mean is written back and the result registered, and the result
// is presented on the outputs. Slot contents are written when a slot is filled or
// its mean is updated; only slots whose valid bit is set are compared, and the valid bits
// live in flip-flops that clear at reset, so no clearing pass is needed.
module per_device_rssi_mean_table
  import rssim_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ADDR_W-1:0]   in_device_address,
  input  wire logic [KIND_W-1:0]   in_address_kind,
  input  wire logic signed [SIG_W-1:0] in_signal_dbm,
  output logic                     out_valid,
  output logic [SLOT_W-1:0]        out_slot_index,
  output logic signed [SIG_W-1:0]  out_average_dbm,
  output logic [SEEN_W-1:0]        out_reports_seen,
  output logic                     out_new_device,
  output logic                     out_table_full_drop
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W = ADDR_W + KIND_W + COUNT_WIDTH + SIG_W;
  localparam int NW    = COUNT_WIDTH + 9;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIVST  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;

  logic [2:0]             state_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // Latched report
  addr_t                  addr_r;
  kind_t                  kind_r;
  sig_t                   sig_r;

  // Scan pointers: idx_r issues reads, pidx_r names the slot whose data is on the RAM output
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       pidx_r;
  logic                   pend_r;
  logic                   iss_done_r;
  logic [IDX_W-1:0]       free_r;
  logic                   have_free_r;

  // Hit slot working set
  logic [IDX_W-1:0]       hit_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  sig_t                   mean_r;
  logic signed [NW-1:0]   num_r;
  logic signed [NW-1:0]   prod;

  // RAM ports
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;

  addr_t                  e_addr;
  kind_t                  e_kind;
  logic [COUNT_WIDTH-1:0] e_cnt;
  sig_t                   e_mean;
  logic                   hit;
  logic                   slot_free;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  // Divider
  logic                   div_start;
  logic                   div_done;
  sig_t                   div_quot;

  // Result registers
  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_slot_r;
  sig_t                   out_mean_r;
  logic [COUNT_WIDTH-1:0] out_cnt_r;
  logic                   out_new_r;
  logic                   out_drop_r;
  logic [IDX_W+SLOT_W-1:0]        slot_ext;
  logic [COUNT_WIDTH+SEEN_W-1:0]  cnt_ext;

  assign {e_addr, e_kind, e_cnt, e_mean} = ram_rdata;
  assign hit       = pend_r && valid_r[pidx_r] && (e_addr == addr_r) && (e_kind == kind_r);
  assign slot_free = pend_r && !valid_r[pidx_r];
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign div_start = (state_r == S_DIVST);

  // Signed product of the stored count and mean, plus the new sample
  assign prod = $signed({1'b0, cnt_r}) * mean_r + NW'(sig_r);

  rssim_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr   (idx_r),
    .rd_data_r (ram_rdata)
  );

  rssim_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r),
    .den    ({1'b0, cnt_r} + (COUNT_WIDTH+1)'(1)),
    .done_r (div_done),
    .quot_r (div_quot)
  );

  // Write port: fill a free slot at the end of a missed scan, or write back an updated mean
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_r;
    ram_wdata = {addr_r, kind_r, cnt_inc, div_quot};
    if (state_r == S_SEARCH && pend_r && !hit && pidx_r == LAST_IDX &&
        (have_free_r || slot_free)) begin
      ram_we    = 1'b1;
      ram_waddr = have_free_r ? free_r : pidx_r;
      ram_wdata = {addr_r, kind_r, COUNT_WIDTH'(1), sig_r};
    end else if (state_r == S_DIV && div_done) begin
      ram_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r     <= S_SEARCH;
            idx_r       <= '0;
            pend_r      <= 1'b0;
            iss_done_r  <= 1'b0;
            have_free_r <= 1'b0;
          end
        end
        S_SEARCH: begin
          // Issue the next slot read until the last one is out
          pend_r <= !iss_done_r;
          pidx_r <= idx_r;
          if (!iss_done_r) begin
            if (idx_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
          // Compare the slot whose data just arrived
          if (hit) begin
            hit_r   <= pidx_r;
            cnt_r   <= e_cnt;
            mean_r  <= e_mean;
            pend_r  <= 1'b0;
            state_r <= S_MUL;
          end else if (pend_r) begin
            if (slot_free && !have_free_r) begin
              free_r      <= pidx_r;
              have_free_r <= 1'b1;
            end
            if (pidx_r == LAST_IDX) begin
              pend_r      <= 1'b0;
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              if (have_free_r || slot_free) begin
                valid_r[have_free_r ? free_r : pidx_r] <= 1'b1;
                out_slot_r <= have_free_r ? free_r : pidx_r;
                out_mean_r <= sig_r;
                out_cnt_r  <= COUNT_WIDTH'(1);
                out_new_r  <= 1'b1;
                out_drop_r <= 1'b0;
              end else begin
                // Table full: drop the report and flag it
                out_slot_r <= '0;
                out_mean_r <= '0;
                out_cnt_r  <= '0;
                out_new_r  <= 1'b0;
                out_drop_r <= 1'b1;
              end
            end
          end
        end
        S_MUL: begin
          num_r   <= prod;
          state_r <= S_DIVST;
        end
        S_DIVST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_slot_r  <= hit_r;
            out_mean_r  <= div_quot;
            out_cnt_r   <= cnt_inc;
            out_new_r   <= 1'b0;
            out_drop_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the report for the whole scan
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      addr_r <= in_device_address;
      kind_r <= in_address_kind;
      sig_r  <= in_signal_dbm;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign slot_ext = {{SLOT_W{1'b0}}, out_slot_r};
  assign cnt_ext  = {{SEEN_W{1'b0}}, out_cnt_r};

  assign out_valid           = out_valid_r;
  assign out_slot_index      = slot_ext[SLOT_W-1:0];
  assign out_average_dbm     = out_mean_r;
  assign out_reports_seen    = cnt_ext[SEEN_W-1:0];
  assign out_new_device      = out_new_r;
  assign out_table_full_drop = out_drop_r;

endmodule

`default_nettype wire

FILE: hdl/rssim_ram.sv
`default_nettype none

module rssim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WIDTH-1:0]     rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/rssim_div.sv
`default_nettype none

// Restoring divider: one compare and subtract per cycle, quotient truncated toward zero.
// The caller guarantees |num| < den * 2^DIV_STEPS.
module rssim_div
  import rssim_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [COUNT_WIDTH+8:0] num,
  input  wire logic [COUNT_WIDTH:0]       den,
  output logic                            done_r,
  output sig_t                            quot_r
);

  localparam int NW = COUNT_WIDTH + 9;
  localparam int MW = NW - 1;

  logic [MW-1:0]         rem_r;
  logic [MW-1:0]         dsh_r;
  logic [SIG_W-1:0]      q_r;
  logic                  neg_r;
  logic                  run_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [NW-1:0]         num_mag;
  logic                  ge;
  logic [SIG_W-1:0]      q_nxt;

  assign num_mag = num[NW-1] ? (~num + NW'(1)) : num;
  assign ge      = (rem_r >= dsh_r);
  assign q_nxt   = {q_r[SIG_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW-1];
      rem_r <= num_mag[MW-1:0];
      dsh_r <= {den, (SIG_W-1)'(0)};
      q_r   <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= q_nxt;
      if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
        quot_r <= neg_r ? sig_t'(~q_nxt + SIG_W'(1)) : sig_t'(q_nxt);
      end
    end
  end

endmodule

`default_nettype wire
